[hw/rtl/frrc_pkg.sv]
// Shared constants, field widths and types of the round-robin collector.
// Used by the channel interfaces and all RTL modules but frrc_ram; depends on nothing.
package frrc_pkg;

   // Sizing of the port queues
   localparam int PORTS      = 8;
   localparam int FIFO_DEPTH = 4;
   localparam int DATA_WIDTH = 32;

   localparam int PORT_W  = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int SLOT_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FILL_W  = $clog2(FIFO_DEPTH + 1);
   localparam int ENTRIES = PORTS * FIFO_DEPTH;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(PORTS + 1);

   // Fixed field widths of the channels
   localparam int OPCODE_W     = 1;
   localparam int PORT_FIELD_W = 3;
   localparam int PAYLOAD_W    = 32;
   localparam int SRC_W        = 3;
   localparam int TAG_W        = 8;
   localparam int DOUT_W       = 32;
   localparam int WAIT_W       = 4;
   localparam int WAIT_MAX     = 15;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_PUSH = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_TICK = 1'b1;

   // Arbitration outcome of one tick
   typedef struct packed {
      logic              found;
      logic [PORT_W-1:0] port;
      logic [WAIT_W-1:0] waiting;
   } grant_type;

   // One result item
   typedef struct packed {
      logic                 sent;
      logic [SRC_W-1:0]     source_port;
      logic [TAG_W-1:0]     tag_bus;
      logic [DOUT_W-1:0]    data_out;
      logic [WAIT_W-1:0]    waiting_inputs;
      logic                 overflow;
   } result_type;

endpackage

[hw/rtl/frrc_if.sv]
// Valid/ready channel interfaces of the round-robin collector.
// Depends on frrc_pkg for the field widths.
interface frrc_req_if;
   logic                                valid;
   logic                                ready;
   logic [frrc_pkg::OPCODE_W-1:0]       opcode;
   logic [frrc_pkg::PORT_FIELD_W-1:0]   port;
   logic [frrc_pkg::PAYLOAD_W-1:0]      payload;

   modport source (output valid, output opcode, output port, output payload, input ready);
   modport sink   (input valid, input opcode, input port, input payload, output ready);
endinterface

interface frrc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                sent;
   logic [frrc_pkg::SRC_W-1:0]          source_port;
   logic [frrc_pkg::TAG_W-1:0]          tag_bus;
   logic [frrc_pkg::DOUT_W-1:0]         data_out;
   logic [frrc_pkg::WAIT_W-1:0]         waiting_inputs;
   logic                                overflow;

   modport source (output valid, output sent, output source_port, output tag_bus,
                   output data_out, output waiting_inputs, output overflow, input ready);
   modport sink   (input valid, input sent, input source_port, input tag_bus,
                   input data_out, input waiting_inputs, input overflow, output ready);
endinterface

interface frrc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [frrc_pkg::TAG_W-1:0]     data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/frrc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; holds the words of all port queues.
module frrc_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/frrc_arb.sv]
// Round-robin pick and occupancy count over the non-empty port queues.
// Depends on frrc_pkg for sizes and grant_type.
module frrc_arb (
   input  logic [frrc_pkg::PORTS-1:0]  busy_mask,
   input  logic [frrc_pkg::PORT_W-1:0] ptr,
   output frrc_pkg::grant_type         grant
);

   always_comb begin
      logic [frrc_pkg::PORT_W:0]   idx_sum;
      logic [frrc_pkg::PORT_W-1:0] idx;
      logic [frrc_pkg::CNT_W-1:0]  cnt;

      grant = '0;
      cnt   = '0;

      // Count the non-empty queues, saturate to the field
      for (int i = 0; i < frrc_pkg::PORTS; i++) begin
         cnt = cnt + frrc_pkg::CNT_W'(busy_mask[i]);
      end
      if (int'(cnt) > frrc_pkg::WAIT_MAX) begin
         grant.waiting = frrc_pkg::WAIT_W'(frrc_pkg::WAIT_MAX);
      end else begin
         grant.waiting = frrc_pkg::WAIT_W'(cnt);
      end

      // Scan from the pointer; walk down so the nearest hit wins
      for (int i = frrc_pkg::PORTS - 1; i >= 0; i--) begin
         idx_sum = {1'b0, ptr} + (frrc_pkg::PORT_W + 1)'(i);
         if (int'(idx_sum) >= frrc_pkg::PORTS) begin
            idx = frrc_pkg::PORT_W'(idx_sum - (frrc_pkg::PORT_W + 1)'(frrc_pkg::PORTS));
         end else begin
            idx = frrc_pkg::PORT_W'(idx_sum);
         end
         if (busy_mask[idx]) begin
            grant.found = 1'b1;
            grant.port  = idx;
         end
      end
   end

endmodule

[hw/rtl/frrc_outbuf.sv]
// Result register with a skid stage in front of the response channel.
// Depends on frrc_pkg (result_type) and frrc_rsp_if.
module frrc_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  frrc_pkg::result_type res,
   output logic                 space,
   frrc_rsp_if.source           rsp_ch
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   frrc_pkg::result_type out_ff, out_in;
   frrc_pkg::result_type skid_ff, skid_in;
   logic                 drain;

   // Place a new item in the output register, or park it in the skid stage
   always_comb begin
      drain         = !out_valid_ff || rsp_ch.ready;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (load) begin
         if (drain) begin
            out_valid_in = 1'b1;
            out_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end else if (drain) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign space                 = !skid_valid_ff;
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.sent           = out_ff.sent;
   assign rsp_ch.source_port    = out_ff.source_port;
   assign rsp_ch.tag_bus        = out_ff.tag_bus;
   assign rsp_ch.data_out       = out_ff.data_out;
   assign rsp_ch.waiting_inputs = out_ff.waiting_inputs;
   assign rsp_ch.overflow       = out_ff.overflow;

endmodule

[hw/rtl/fifo_round_robin_collector.sv]
// Round-robin collector: per-port queues in one RAM, arbiter, result buffer.
// Depends on frrc_pkg, frrc_if, frrc_ram, frrc_arb and frrc_outbuf.
//
// Usage:
//   req_ch carries one item per handshake: a push (opcode 0) appends payload
//   to the queue of port; a tick (opcode 1) counts the non-empty queues,
//   pops the first non-empty one found from the round-robin pointer and
//   returns its word tagged with bus_id and the source port.
//   rsp_ch returns exactly one result item per request item, in order.
//   csr_ch writes bus_id; it is always ready and takes effect next cycle.
//   A push result enters the result buffer when the push is accepted. A tick
//   first waits in a read state for the registered read data of the queue RAM,
//   with req_ch not ready; its result then enters the result buffer.
//   Reset (synchronous, active high) empties all queues, zeroes the pointer
//   and bus_id; no clearing pass is needed, queue words are read only after
//   they are written.
//   When rsp_ch stalls, one further result is parked in a skid stage; req_ch
//   drops ready while that stage is occupied.
module fifo_round_robin_collector (
   input  logic       clock,
   input  logic       reset,
   frrc_req_if.sink   req_ch,
   frrc_rsp_if.source rsp_ch,
   frrc_csr_if.sink   csr_ch
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                               state_ff, state_in;
   logic [frrc_pkg::TAG_W-1:0]         bus_id_ff, bus_id_in;
   logic [frrc_pkg::SLOT_W-1:0]        head_ff [frrc_pkg::PORTS];
   logic [frrc_pkg::SLOT_W-1:0]        head_in [frrc_pkg::PORTS];
   logic [frrc_pkg::SLOT_W-1:0]        tail_ff [frrc_pkg::PORTS];
   logic [frrc_pkg::SLOT_W-1:0]        tail_in [frrc_pkg::PORTS];
   logic [frrc_pkg::FILL_W-1:0]        fill_ff [frrc_pkg::PORTS];
   logic [frrc_pkg::FILL_W-1:0]        fill_in [frrc_pkg::PORTS];
   logic [frrc_pkg::PORT_W-1:0]        ptr_ff, ptr_in;
   frrc_pkg::grant_type                grant_ff, grant_in;

   logic [frrc_pkg::PORTS-1:0]         busy_mask;
   frrc_pkg::grant_type                grant;
   logic                               accept, is_push, is_tick;
   logic [frrc_pkg::PORT_W-1:0]        push_port;
   logic                               port_ok, full;
   logic                               wr_en, rd_en;
   logic [frrc_pkg::ADDR_W-1:0]        wr_addr, rd_addr;
   logic [frrc_pkg::DATA_WIDTH-1:0]    wr_data, rd_data;
   logic                               buf_space, load;
   frrc_pkg::result_type               res;

   function automatic logic [frrc_pkg::SLOT_W-1:0] next_slot(
      input logic [frrc_pkg::SLOT_W-1:0] slot);
      if (slot == frrc_pkg::SLOT_W'(frrc_pkg::FIFO_DEPTH - 1)) begin
         return '0;
      end
      return slot + 1'b1;
   endfunction

   function automatic logic [frrc_pkg::PORT_W-1:0] next_port(
      input logic [frrc_pkg::PORT_W-1:0] port);
      if (port == frrc_pkg::PORT_W'(frrc_pkg::PORTS - 1)) begin
         return '0;
      end
      return port + 1'b1;
   endfunction

   // Handshakes
   assign req_ch.ready = (state_ff == ST_IDLE) && buf_space;
   assign csr_ch.ready = 1'b1;
   assign accept  = req_ch.valid && req_ch.ready;
   assign is_push = accept && (req_ch.opcode == frrc_pkg::OP_PUSH);
   assign is_tick = accept && (req_ch.opcode == frrc_pkg::OP_TICK);

   // Occupancy and arbitration
   always_comb begin
      for (int i = 0; i < frrc_pkg::PORTS; i++) begin
         busy_mask[i] = (fill_ff[i] != '0);
      end
   end

   frrc_arb u_arb (
      .busy_mask (busy_mask),
      .ptr       (ptr_ff),
      .grant     (grant)
   );

   // Push addressing
   assign push_port = frrc_pkg::PORT_W'(req_ch.port);
   assign port_ok   = int'(req_ch.port) < frrc_pkg::PORTS;
   assign full      = fill_ff[push_port] >= frrc_pkg::FILL_W'(frrc_pkg::FIFO_DEPTH);
   assign wr_en     = is_push && port_ok && !full;
   assign wr_addr   = frrc_pkg::ADDR_W'(push_port) * frrc_pkg::ADDR_W'(frrc_pkg::FIFO_DEPTH)
                      + frrc_pkg::ADDR_W'(tail_ff[push_port]);
   assign wr_data   = frrc_pkg::DATA_WIDTH'(req_ch.payload);

   // Pop addressing
   assign rd_en   = is_tick && grant.found;
   assign rd_addr = frrc_pkg::ADDR_W'(grant.port) * frrc_pkg::ADDR_W'(frrc_pkg::FIFO_DEPTH)
                    + frrc_pkg::ADDR_W'(head_ff[grant.port]);

   frrc_ram #(
      .WIDTH  (frrc_pkg::DATA_WIDTH),
      .DEPTH  (frrc_pkg::ENTRIES),
      .ADDR_W (frrc_pkg::ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Advance queue pointers, fill counts, round-robin pointer, state, bus_id and grant
   always_comb begin
      state_in  = state_ff;
      bus_id_in = bus_id_ff;
      ptr_in    = ptr_ff;
      grant_in  = grant_ff;
      for (int i = 0; i < frrc_pkg::PORTS; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
         fill_in[i] = fill_ff[i];
      end

      if (csr_ch.valid) begin
         bus_id_in = csr_ch.data;
      end

      if (wr_en) begin
         tail_in[push_port] = next_slot(tail_ff[push_port]);
         fill_in[push_port] = fill_ff[push_port] + 1'b1;
      end

      if (rd_en) begin
         head_in[grant.port] = next_slot(head_ff[grant.port]);
         fill_in[grant.port] = fill_ff[grant.port] - 1'b1;
         ptr_in              = next_port(grant.port);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (is_tick) begin
               state_in = ST_READ;
               grant_in = grant;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         bus_id_ff <= '0;
         ptr_ff    <= '0;
         for (int i = 0; i < frrc_pkg::PORTS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         bus_id_ff <= bus_id_in;
         ptr_ff    <= ptr_in;
         for (int i = 0; i < frrc_pkg::PORTS; i++) begin
            head_ff[i] <= head_in[i];
            tail_ff[i] <= tail_in[i];
            fill_ff[i] <= fill_in[i];
         end
      end
   end

   // Hold the grant while the RAM read completes
   always_ff @(posedge clock) begin
      grant_ff <= grant_in;
   end

   // Form the result item: push results at acceptance, tick results after the read
   always_comb begin
      res  = '0;
      load = 1'b0;
      if (is_push) begin
         load         = 1'b1;
         res.overflow = port_ok && full;
      end else if (state_ff == ST_READ) begin
         load               = 1'b1;
         res.waiting_inputs = grant_ff.waiting;
         if (grant_ff.found) begin
            res.sent        = 1'b1;
            res.source_port = frrc_pkg::SRC_W'(grant_ff.port);
            res.tag_bus     = bus_id_ff;
            res.data_out    = frrc_pkg::DOUT_W'(rd_data);
         end
      end
   end

   frrc_outbuf u_outbuf (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .res    (res),
      .space  (buf_space),
      .rsp_ch (rsp_ch)
   );

endmodule
